FILE: src/rsplot_pkg.sv
// shared types for the raster shape plotter
package rsplot_pkg;

   typedef enum logic [1:0] {
      FUNC_READ   = 2'd0,
      FUNC_SQUARE = 2'd1,
      FUNC_DISC   = 2'd2,
      FUNC_LINE   = 2'd3
   } func_type;

   typedef struct packed {
      func_type           func;
      logic [7:0]         x0;
      logic [7:0]         y0;
      logic [7:0]         x1;
      logic [7:0]         y1;
      logic [5:0]         size;
      logic [3:0]         material;
      logic signed [7:0]  lo;
      logic signed [7:0]  hi;
      logic               skip;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic ready;
   } back_ctrl_type;

endpackage

FILE: src/rsplot_ram.sv
// generic single write port ram with registered read
module rsplot_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rsplot_front.sv
// command intake, decode and queue
module rsplot_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_func,
   input  logic [7:0]              req_x0,
   input  logic [7:0]              req_y0,
   input  logic [7:0]              req_x1,
   input  logic [7:0]              req_y1,
   input  logic [5:0]              req_shape_size,
   input  logic [3:0]              req_material,
   input  rsplot_pkg::back_ctrl_type back_ctrl,
   output logic                    cmd_valid,
   output rsplot_pkg::cmd_type     cmd
);

   localparam int QUEUE_DEPTH = 2;
   localparam int PW = $clog2(QUEUE_DEPTH);

   rsplot_pkg::cmd_type q_ff [QUEUE_DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PW:0]   cnt_ff, cnt_in;
   rsplot_pkg::cmd_type dec;
   logic [4:0] half;
   logic push;

   always_comb begin
      half = req_shape_size[5:1];
      dec.func = rsplot_pkg::func_type'(req_func);
      dec.x0 = req_x0;
      dec.y0 = req_y0;
      dec.x1 = req_x1;
      dec.y1 = req_y1;
      dec.size = req_shape_size;
      dec.material = req_material;
      dec.skip = 1'b0;
      case (dec.func)
         rsplot_pkg::FUNC_READ: begin
            dec.lo = 8'sd0;
            dec.hi = 8'sd0;
         end
         rsplot_pkg::FUNC_DISC: begin
            dec.lo = $signed(8'd0 - {3'b000, half});
            dec.hi = $signed({3'b000, half} + {7'd0, req_shape_size[0]});
         end
         default: begin
            dec.lo = $signed(8'd0 - {3'b000, half});
            dec.hi = $signed({3'b000, half} + {7'd0, req_shape_size[0]} - 8'd1);
            dec.skip = (req_shape_size == 6'd0);
         end
      endcase
   end

   assign req_stall = (cnt_ff == (PW+1)'(QUEUE_DEPTH)) || !back_ctrl.ready;
   assign push = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd = q_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = back_ctrl.pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(back_ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wptr_ff] <= dec;
      end
   end

endmodule

FILE: src/rsplot_back.sv
// command execution against the material grid
module rsplot_back #(
   parameter int GRID_WIDTH = 128,
   parameter int GRID_HEIGHT = 128,
   parameter int MATERIAL_BITS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  rsplot_pkg::cmd_type       cmd,
   output rsplot_pkg::back_ctrl_type back_ctrl,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [3:0]                rsp_cell_value
);

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW = $clog2(CELLS);

   typedef enum logic [7:0] {
      ST_CLEAR     = 8'b0000_0001,
      ST_IDLE      = 8'b0000_0010,
      ST_READ      = 8'b0000_0100,
      ST_READ_WAIT = 8'b0000_1000,
      ST_VISIT     = 8'b0001_0000,
      ST_UPDATE    = 8'b0010_0000,
      ST_STEP      = 8'b0100_0000,
      ST_DONE      = 8'b1000_0000
   } back_state_type;

   back_state_type state_ff, state_in;
   rsplot_pkg::cmd_type cmd_ff, cmd_in;
   logic [7:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [7:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [10:0] dy2_ff, dy2_in;
   logic [9:0] lim_ff, lim_in;
   logic signed [11:0] err_ff, err_in;
   logic [AW-1:0] addr_ff, addr_in, clr_ff, clr_in;
   logic wr_ok_ff, wr_ok_in, on_ff, on_in;
   logic [3:0] res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_value_ff, rsp_value_in;

   logic signed [10:0] px, py;
   logic on_grid, in_disc, last, wrap_x, changeable;
   logic [11:0] dx2;
   logic [AW-1:0] cell_addr;
   logic [MATERIAL_BITS+3:0] mat_wide;
   logic [MATERIAL_BITS-1:0] mat;
   logic [MATERIAL_BITS+3:0] rd_wide;
   logic [MATERIAL_BITS-1:0] rd_data;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [MATERIAL_BITS-1:0] wr_data;
   logic [7:0] ddx, dymag, sddx, sdymag;
   logic [4:0] r;
   logic [5:0] ro;
   logic signed [12:0] e2;
   logic xc, yc;
   logic signed [7:0] dy_n;
   logic signed [7:0] lo_sq_src;

   rsplot_ram #(.WIDTH(MATERIAL_BITS), .DEPTH(CELLS)) u_grid (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(cell_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      px = $signed({3'b000, cx_ff}) + 11'(dx_ff);
      py = $signed({3'b000, cy_ff}) + 11'(dy_ff);
      on_grid = (px >= 11'sd0) && (px < 11'(GRID_WIDTH)) &&
                (py >= 11'sd0) && (py < 11'(GRID_HEIGHT));
      cell_addr = AW'(AW'(py[8:0]) * AW'(GRID_WIDTH) + AW'(px[8:0]));
      dx2 = 12'(dx_ff * dx_ff);
      in_disc = (dx2 + {1'b0, dy2_ff}) <= {2'b00, lim_ff};
      wrap_x = (dx_ff == cmd_ff.hi);
      last = wrap_x && (dy_ff == cmd_ff.hi);
      dy_n = dy_ff + 8'sd1;
      mat_wide = {{MATERIAL_BITS{1'b0}}, cmd_ff.material};
      mat = mat_wide[MATERIAL_BITS-1:0];
      rd_wide = {4'b0000, rd_data};
      changeable = (mat != '0) ? (rd_data == '0) : (rd_data != '0);
      sddx = (cmd_ff.x1 >= cmd_ff.x0) ? cmd_ff.x1 - cmd_ff.x0 : cmd_ff.x0 - cmd_ff.x1;
      sdymag = (cmd_ff.y1 >= cmd_ff.y0) ? cmd_ff.y1 - cmd_ff.y0 : cmd_ff.y0 - cmd_ff.y1;
      e2 = $signed({err_ff, 1'b0});
      xc = e2 >= (13'sd0 - $signed({5'b00000, sdymag}));
      yc = e2 <= $signed({5'b00000, sddx});
      ddx = (cmd.x1 >= cmd.x0) ? cmd.x1 - cmd.x0 : cmd.x0 - cmd.x1;
      dymag = (cmd.y1 >= cmd.y0) ? cmd.y1 - cmd.y0 : cmd.y0 - cmd.y1;
      r = cmd.size[5:1];
      ro = {1'b0, r} + {5'd0, cmd.size[0]};
      lo_sq_src = cmd.lo;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      dy2_in = dy2_ff;
      lim_in = lim_ff;
      err_in = err_ff;
      addr_in = addr_ff;
      clr_in = clr_ff;
      wr_ok_in = wr_ok_ff;
      on_in = on_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      back_ctrl.pop = 1'b0;
      back_ctrl.ready = (state_ff != ST_CLEAR);
      wr_en = 1'b0;
      wr_addr = cell_addr;
      wr_data = mat;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               back_ctrl.pop = 1'b1;
               cmd_in = cmd;
               cx_in = cmd.x0;
               cy_in = cmd.y0;
               dx_in = cmd.lo;
               dy_in = cmd.lo;
               dy2_in = 11'(lo_sq_src * lo_sq_src);
               lim_in = 10'(r * ro);
               err_in = $signed({4'b0000, ddx}) - $signed({4'b0000, dymag});
               res_in = '0;
               if (cmd.func == rsplot_pkg::FUNC_READ) begin
                  state_in = ST_READ;
               end else if (cmd.skip) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_VISIT;
               end
            end
         end
         ST_READ: begin
            on_in = on_grid;
            state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            res_in = on_ff ? rd_wide[3:0] : 4'd0;
            state_in = ST_DONE;
         end
         ST_VISIT: begin
            if (cmd_ff.func == rsplot_pkg::FUNC_LINE) begin
               wr_en = on_grid;
               if (last) begin
                  state_in = ST_STEP;
               end
            end else begin
               addr_in = cell_addr;
               wr_ok_in = on_grid && ((cmd_ff.func == rsplot_pkg::FUNC_SQUARE) || in_disc);
               state_in = ST_UPDATE;
            end
            if (!(cmd_ff.func != rsplot_pkg::FUNC_LINE) || 1'b1) begin
               if (cmd_ff.func == rsplot_pkg::FUNC_LINE) begin
                  dx_in = wrap_x ? cmd_ff.lo : dx_ff + 8'sd1;
                  if (wrap_x) begin
                     dy_in = last ? cmd_ff.lo : dy_n;
                  end
               end
            end
         end
         ST_UPDATE: begin
            wr_en = wr_ok_ff && changeable;
            wr_addr = addr_ff;
            dx_in = wrap_x ? cmd_ff.lo : dx_ff + 8'sd1;
            if (wrap_x) begin
               dy_in = dy_n;
               dy2_in = 11'(dy_n * dy_n);
            end
            state_in = last ? ST_DONE : ST_VISIT;
         end
         ST_STEP: begin
            if ((xc && cx_ff == cmd_ff.x1) || (yc && cy_ff == cmd_ff.y1)) begin
               state_in = ST_DONE;
            end else begin
               err_in = err_ff + (xc ? 12'sd0 - $signed({4'b0000, sdymag}) : 12'sd0)
                               + (yc ? $signed({4'b0000, sddx}) : 12'sd0);
               if (xc) begin
                  cx_in = (cx_ff < cmd_ff.x1) ? cx_ff + 8'd1 : cx_ff - 8'd1;
               end
               if (yc) begin
                  cy_in = (cy_ff < cmd_ff.y1) ? cy_ff + 8'd1 : cy_ff - 8'd1;
               end
               dx_in = cmd_ff.lo;
               dy_in = cmd_ff.lo;
               state_in = ST_VISIT;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      dy2_ff <= dy2_in;
      lim_ff <= lim_in;
      err_ff <= err_in;
      addr_ff <= addr_in;
      wr_ok_ff <= wr_ok_in;
      on_ff <= on_in;
      res_ff <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;

endmodule

FILE: src/raster_shape_plotter_top.sv
// top level of the raster shape plotter
// After reset the grid of GRID_WIDTH*GRID_HEIGHT cells (16384 at the
// defaults) is cleared one cell per cycle, with req_stall held high. A read
// command reads the grid and then waits for the registered read data; a
// square or disc fill visits each cell of its bounding box (a grid read then
// a conditional write on the one grid ram port); a thick line stamps the
// cells of its square at each point, then takes a line step. Commands are
// queued two deep ahead of the executor, and each gives one rsp transfer.
module raster_shape_plotter_top #(
   parameter int GRID_WIDTH = 128,
   parameter int GRID_HEIGHT = 128,
   parameter int MATERIAL_BITS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_x0,
   input  logic [7:0] req_y0,
   input  logic [7:0] req_x1,
   input  logic [7:0] req_y1,
   input  logic [5:0] req_shape_size,
   input  logic [3:0] req_material,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_cell_value
);

   rsplot_pkg::back_ctrl_type back_ctrl;
   rsplot_pkg::cmd_type cmd;
   logic cmd_valid;

   rsplot_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_x0        (req_x0),
      .req_y0        (req_y0),
      .req_x1        (req_x1),
      .req_y1        (req_y1),
      .req_shape_size(req_shape_size),
      .req_material  (req_material),
      .back_ctrl     (back_ctrl),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd)
   );

   rsplot_back #(
      .GRID_WIDTH   (GRID_WIDTH),
      .GRID_HEIGHT  (GRID_HEIGHT),
      .MATERIAL_BITS(MATERIAL_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .back_ctrl     (back_ctrl),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_value(rsp_cell_value)
   );

endmodule

FILE: src/rsplot_checker.sv
// port level checks for the raster shape plotter and their binding
module rsplot_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_cell_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp transfer dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_cell_value))
      else $error("rsp payload changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid straight after reset");

   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("req taken during grid clear");

endmodule

bind raster_shape_plotter_top rsplot_checker u_rsplot_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_cell_value(rsp_cell_value)
);
